@@ sv/cfbi_pkg.sv @@
// Package for the composite-field byte inverse block.
// Holds the GF(16) arithmetic helpers and the pipeline stage records.
// No dependencies.
`default_nettype none

package cfbi_pkg;

  localparam int unsigned NibW = 4;
  localparam int unsigned ByteW = 8;

  typedef logic [NibW-1:0] nib_t;
  typedef logic [ByteW-1:0] byte_t;

  // x^4 + x + 1, low bits after the x^4 term drops out
  localparam nib_t GfReduce = 4'h3;
  localparam nib_t ConstResetVal = 4'h1;

  // Stage 1 record: operands and the three partial products of the norm
  typedef struct packed {
    nib_t hi;
    nib_t lo;
    nib_t hi_sq;
    nib_t hi_lo;
    nib_t lo_sq;
  } prod_t;

  // Stage 2 record: operands and the inverse of the norm
  typedef struct packed {
    nib_t hi;
    nib_t lo;
    nib_t norm_inv;
  } norm_t;

  function automatic nib_t gf16_double(input nib_t v);
    nib_t r;
    r = {v[NibW-2:0], 1'b0};
    if (v[NibW-1]) begin
      r = r ^ GfReduce;
    end
    return r;
  endfunction

  function automatic nib_t gf16_mul(input nib_t a, input nib_t b);
    nib_t acc;
    nib_t t;
    acc = '0;
    t = a;
    for (int i = 0; i < NibW; i++) begin
      if (b[i]) begin
        acc = acc ^ t;
      end
      t = gf16_double(t);
    end
    return acc;
  endfunction

  // Inverse over GF(16); zero maps to zero
  function automatic nib_t gf16_inv(input nib_t v);
    nib_t r;
    case (v)
      4'h0: r = 4'h0;
      4'h1: r = 4'h1;
      4'h2: r = 4'h9;
      4'h3: r = 4'he;
      4'h4: r = 4'hd;
      4'h5: r = 4'hb;
      4'h6: r = 4'h7;
      4'h7: r = 4'h6;
      4'h8: r = 4'hf;
      4'h9: r = 4'h2;
      4'ha: r = 4'hc;
      4'hb: r = 4'h5;
      4'hc: r = 4'ha;
      4'hd: r = 4'h4;
      4'he: r = 4'h3;
      4'hf: r = 4'h8;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/cfbi_prod.sv @@
// Stage 1 of the inverse pipeline: splits the byte and forms b^2, b*c, c^2.
// Depends on cfbi_pkg.
`default_nettype none

module cfbi_prod (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           valid_i,
  input  wire cfbi_pkg::byte_t value_i,
  output logic                ready_o,
  output logic                valid_o,
  output cfbi_pkg::prod_t     data_o,
  input  wire logic           ready_i
);
  import cfbi_pkg::*;

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;
  nib_t  hi;
  nib_t  lo;

  assign hi = value_i[ByteW-1:NibW];
  assign lo = value_i[NibW-1:0];

  always_comb begin
    data_nxt.hi    = hi;
    data_nxt.lo    = lo;
    data_nxt.hi_sq = gf16_mul(hi, hi);
    data_nxt.hi_lo = gf16_mul(hi, lo);
    data_nxt.lo_sq = gf16_mul(lo, lo);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

@@ sv/cfbi_norm.sv @@
// Stage 2 of the inverse pipeline: norm d = b^2*B + b*c + c^2 and its inverse.
// Depends on cfbi_pkg.
`default_nettype none

module cfbi_norm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cfbi_pkg::nib_t  sub_const_i,
  input  wire logic            valid_i,
  input  wire cfbi_pkg::prod_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output cfbi_pkg::norm_t      data_o,
  input  wire logic            ready_i
);
  import cfbi_pkg::*;

  logic  valid_r;
  norm_t data_r;
  norm_t data_nxt;
  nib_t  norm;

  assign norm = gf16_mul(data_i.hi_sq, sub_const_i) ^ data_i.hi_lo ^ data_i.lo_sq;

  always_comb begin
    data_nxt.hi       = data_i.hi;
    data_nxt.lo       = data_i.lo;
    data_nxt.norm_inv = gf16_inv(norm);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

@@ sv/cfbi_scale.sv @@
// Stage 3 of the inverse pipeline: p = b/d, q = (b+c)/d into the output register.
// Depends on cfbi_pkg.
`default_nettype none

module cfbi_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            valid_i,
  input  wire cfbi_pkg::norm_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output cfbi_pkg::byte_t      inverse_o,
  input  wire logic            ready_i
);
  import cfbi_pkg::*;

  logic  valid_r;
  byte_t inverse_r;
  byte_t inverse_nxt;

  assign inverse_nxt = {gf16_mul(data_i.norm_inv, data_i.hi),
                        gf16_mul(data_i.norm_inv, data_i.hi ^ data_i.lo)};

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      inverse_r <= inverse_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign inverse_o = inverse_r;

endmodule

`default_nettype wire

@@ sv/composite_field_byte_inverse_top.sv @@
// Top level of the composite-field byte inverse block.
// Depends on cfbi_pkg, cfbi_prod, cfbi_norm and cfbi_scale.
`default_nettype none

// Inverts a byte b*y+c in GF((2^4)^2), GF(16) over x^4+x+1, extension y^2+y+B
// with B set through the cfg port (reset value 1). Three register stages:
// partial products, norm and its inverse, final scaling into the output
// register. One item is accepted per cycle while the output is not stalled.
// Each stage holds its item on out_stall and admits a new one as soon as it
// empties, so bubbles are squeezed out. A norm of zero gives an inverse of
// 0. cfg_ready is always high; write B only while the pipeline is empty.
module composite_field_byte_inverse_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire cfbi_pkg::byte_t in_value,
  output logic                out_valid,
  input  wire logic           out_stall,
  output cfbi_pkg::byte_t     out_inverse,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire cfbi_pkg::nib_t cfg_subfield_constant
);
  import cfbi_pkg::*;

  nib_t  sub_const_r;
  logic  prod_ready;
  logic  prod_valid;
  prod_t prod_data;
  logic  norm_ready;
  logic  norm_valid;
  norm_t norm_data;
  logic  scale_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_const_r <= ConstResetVal;
    end else if (cfg_valid && cfg_ready) begin
      sub_const_r <= cfg_subfield_constant;
    end
  end

  cfbi_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .value_i (in_value),
    .ready_o (prod_ready),
    .valid_o (prod_valid),
    .data_o  (prod_data),
    .ready_i (norm_ready)
  );

  cfbi_norm u_norm (
    .clk         (clk),
    .rst_n       (rst_n),
    .sub_const_i (sub_const_r),
    .valid_i     (prod_valid),
    .data_i      (prod_data),
    .ready_o     (norm_ready),
    .valid_o     (norm_valid),
    .data_o      (norm_data),
    .ready_i     (scale_ready)
  );

  cfbi_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (norm_valid),
    .data_i    (norm_data),
    .ready_o   (scale_ready),
    .valid_o   (out_valid),
    .inverse_o (out_inverse),
    .ready_i   (!out_stall)
  );

  assign in_stall = !prod_ready;

`ifndef SYNTHESIS
  // zero norm inverse must come out as zero
  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (norm_valid && scale_ready && norm_data.norm_inv == '0) |=> (out_inverse == '0))
    else $error("zero norm did not give a zero inverse");

  // a waiting stage-2 item fills the output once it drains
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (norm_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("output not refilled from stage 2");

  // nothing leaves the pipe right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input is never held off while the whole pipe can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_stall) |-> !in_stall)
    else $error("input stalled with output free");
`endif

endmodule

`default_nettype wire
